// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion violated");
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion violated");
`else
`define ASSERT_IMP(lbl, clk, rst_n, a, b)
`define ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/mlqs_pkg.sv =====
`timescale 1ns / 1ps
package mlqs_pkg;

  // function codes
  localparam logic [2:0] FN_ADMIT  = 3'd0;
  localparam logic [2:0] FN_STATE  = 3'd1;
  localparam logic [2:0] FN_CHGQ   = 3'd2;
  localparam logic [2:0] FN_AGE    = 3'd3;
  localparam logic [2:0] FN_SCHED  = 3'd4;

  // queue classes
  localparam logic [1:0] Q_RR = 2'd0;
  localparam logic [1:0] Q_LC = 2'd1;
  localparam logic [1:0] Q_BJ = 2'd2;

  // task states
  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_RUNNABLE = 2'd1;
  localparam logic [1:0] ST_BLOCKED  = 2'd2;

  // picked_from codes
  localparam logic [1:0] FROM_RR   = 2'd0;
  localparam logic [1:0] FROM_LC   = 2'd1;
  localparam logic [1:0] FROM_BJ   = 2'd2;
  localparam logic [1:0] FROM_NONE = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_AGING = 3'd0;
  localparam logic [2:0] REG_PRIO  = 3'd1;
  localparam logic [2:0] REG_ARR   = 3'd2;
  localparam logic [2:0] REG_EXEC  = 3'd3;
  localparam logic [2:0] REG_SIZE  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_AGE,
    S_SCHED,
    S_RESP
  } fsm_t;

  // one task table entry
  typedef struct packed {
    logic [1:0]  state;
    logic [1:0]  queue;
    logic [31:0] arrival;
    logic [31:0] run_stamp;
    logic [7:0]  prio;
    logic [15:0] size;
    logic [15:0] tenths;
  } entry_t;

endpackage

// ===== hdl/multilevel_queue_scheduler.sv =====
`timescale 1ns / 1ps
// Multilevel queue scheduler with aging over a task table held in one
// synchronous RAM (one write port, one registered read port).
// in_*: one command transaction per item, tdata holds from bit 0 up:
//   func[2:0], slot[8:3], queue_class[10:9], task_state[12:11], now[44:13],
//   priority_req[52:45], task_size[68:53].
// out_*: exactly one result transaction per command: found[0],
//   chosen_slot[6:1], prev_queue[8:7], picked_from[10:9].
// cfg_*: register writes (index 0 aging threshold, 1..4 rank weights);
//   write only while no command is in flight.
// Steps after acceptance: admit writes the entry, set state / change queue
// read it and then write it, an unknown function goes straight to the
// response, age scans the table, schedule scans and then does a
// read-modify-write of the pick (one RAM read per cycle in the scan, then the
// read and rank stages drain). One command at a time; the next is taken in
// the cycle after the result enters the output register.
// Reset clears all entries to unused through per-entry valid bits at once;
// no clearing pass. A stalled receiver holds the result; a finished
// command waits in its response state until the output register frees.
module multilevel_queue_scheduler #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func, slot, queue_class, task_state, now, priority_req, task_size
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // found, chosen_slot, prev_queue, picked_from
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import mlqs_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = IW + 1;

  // configuration
  logic [31:0] thr_r;
  logic [15:0] pw_r, aw_r, ew_r, sw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'd8000;
      pw_r  <= 16'd256;
      aw_r  <= 16'd256;
      ew_r  <= 16'd256;
      sw_r  <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AGING: thr_r <= cfg_wdata;
        REG_PRIO:  pw_r  <= cfg_wdata[15:0];
        REG_ARR:   aw_r  <= cfg_wdata[15:0];
        REG_EXEC:  ew_r  <= cfg_wdata[15:0];
        REG_SIZE:  sw_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // command fields
  logic [2:0]  in_func;
  logic [5:0]  in_slot;
  logic [1:0]  in_qc, in_ts;
  assign in_func = in_tdata[2:0];
  assign in_slot = in_tdata[8:3];
  assign in_qc   = in_tdata[10:9];
  assign in_ts   = in_tdata[12:11];

  fsm_t state_r, state_nxt;
  logic [2:0]  func_r;
  logic [1:0]  qc_r, ts_r;
  logic [31:0] now_r;
  logic [7:0]  prio_r;
  logic [15:0] size_r;
  logic [IW-1:0] addr_r, addr_nxt;
  logic        accept;
  logic        slot_ok;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_ok   = (32'(in_slot) < 32'(ENTRIES));

  // table RAM and valid bits
  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  entry_t rd_data_r;
  logic   rdv_r;
  logic [IW-1:0] rd_addr;
  logic   mem_we;
  logic [IW-1:0] mem_wa;
  entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= vld_r[rd_addr];
      if (mem_we) vld_r[mem_wa] <= 1'b1;
    end
  end

  logic [1:0] eff_state;
  assign eff_state = rdv_r ? rd_data_r.state : ST_UNUSED;

  // scan counter and rank pipeline
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          issue;
  logic          p1_v_r, p2_v_r, p3_v_r;
  logic [IW-1:0] p1_idx_r, p2_idx_r, p3_idx_r;
  logic          p2_el_r, p3_el_r;
  logic [23:0]   m_p_r;
  logic [47:0]   m_a_r;
  logic [31:0]   m_s_r, m_t_r;
  logic [49:0]   s3_r;
  logic [31:0]   t3_r;
  logic [53:0]   rank4;
  logic          scanning, scan_done;

  assign scanning  = (state_r == S_AGE) || (state_r == S_SCHED);
  assign issue     = scanning && (cnt_r < CW'(ENTRIES));
  assign scan_done = (cnt_r == CW'(ENTRIES)) && !p1_v_r && !p2_v_r && !p3_v_r;
  assign rank4     = ({1'b0, s3_r, 3'b000} + {3'b000, s3_r, 1'b0}) + 54'(t3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  // advance rank stages
  always_ff @(posedge clk) begin
    p1_idx_r <= cnt_r[IW-1:0];
    p2_idx_r <= p1_idx_r;
    p3_idx_r <= p2_idx_r;
    p2_el_r  <= (eff_state == ST_RUNNABLE) && (rd_data_r.queue == Q_BJ);
    p3_el_r  <= p2_el_r;
    m_p_r    <= 24'(rd_data_r.prio) * 24'(pw_r);
    m_a_r    <= 48'(rd_data_r.arrival) * 48'(aw_r);
    m_s_r    <= 32'(rd_data_r.size) * 32'(sw_r);
    m_t_r    <= 32'(rd_data_r.tenths) * 32'(ew_r);
    s3_r     <= 50'(m_p_r) + 50'(m_a_r) + 50'(m_s_r);
    t3_r     <= m_t_r;
  end

  // candidate tracking
  logic          rrh_r, rrl_r, lc_r, bj_r;
  logic [IW-1:0] rrh_idx_r, rrl_idx_r, lc_idx_r, bj_idx_r;
  logic [31:0]   lc_arr_r;
  logic [53:0]   bj_rank_r;
  logic [IW-1:0] lrr_r;
  logic          p1_rr, p1_lc;

  assign p1_rr = p1_v_r && (state_r == S_SCHED) && (eff_state == ST_RUNNABLE)
                 && (rd_data_r.queue == Q_RR);
  assign p1_lc = p1_v_r && (state_r == S_SCHED) && (eff_state == ST_RUNNABLE)
                 && (rd_data_r.queue == Q_LC);

  always_ff @(posedge clk) begin
    if (!rst_n || accept) begin
      rrh_r <= 1'b0;
      rrl_r <= 1'b0;
      lc_r  <= 1'b0;
      bj_r  <= 1'b0;
    end else begin
      if (p1_rr && (p1_idx_r > lrr_r) && !rrh_r) begin
        rrh_r     <= 1'b1;
        rrh_idx_r <= p1_idx_r;
      end
      if (p1_rr && (p1_idx_r <= lrr_r) && !rrl_r) begin
        rrl_r     <= 1'b1;
        rrl_idx_r <= p1_idx_r;
      end
      if (p1_lc && (!lc_r || (rd_data_r.arrival > lc_arr_r))) begin
        lc_r     <= 1'b1;
        lc_idx_r <= p1_idx_r;
        lc_arr_r <= rd_data_r.arrival;
      end
      if (p3_v_r && p3_el_r && (state_r == S_SCHED) && (!bj_r || rank4 < bj_rank_r)) begin
        bj_r      <= 1'b1;
        bj_idx_r  <= p3_idx_r;
        bj_rank_r <= rank4;
      end
    end
  end

  // schedule decision
  logic          have;
  logic [IW-1:0] pick;
  logic [1:0]    pick_from;
  always_comb begin
    have      = 1'b1;
    pick      = bj_idx_r;
    pick_from = FROM_BJ;
    if (rrh_r) begin
      pick      = rrh_idx_r;
      pick_from = FROM_RR;
    end else if (rrl_r) begin
      pick      = rrl_idx_r;
      pick_from = FROM_RR;
    end else if (lc_r) begin
      pick      = lc_idx_r;
      pick_from = FROM_LC;
    end else if (!bj_r) begin
      have      = 1'b0;
      pick_from = FROM_NONE;
    end
  end

  // next state
  logic out_free;
  logic out_tvalid_r;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func) inside
            FN_ADMIT:          state_nxt = slot_ok ? S_WR : S_RESP;
            FN_STATE, FN_CHGQ: state_nxt = slot_ok ? S_RD : S_RESP;
            FN_AGE:            state_nxt = S_AGE;
            FN_SCHED:          state_nxt = S_SCHED;
            default:           state_nxt = S_RESP;
          endcase
        end
      end
      S_RD:    state_nxt = S_WR;
      S_WR:    state_nxt = S_RESP;
      S_AGE:   if (scan_done) state_nxt = S_RESP;
      S_SCHED: if (scan_done) state_nxt = have ? S_RD : S_RESP;
      S_RESP:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM access and counters
  entry_t wd;
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = addr_r;
    wd       = rd_data_r;
    rd_addr  = scanning ? cnt_r[IW-1:0] : addr_r;
    cnt_nxt  = issue ? cnt_r + CW'(1) : cnt_r;
    addr_nxt = addr_r;
    if (accept) begin
      cnt_nxt  = '0;
      addr_nxt = IW'(in_slot);
    end
    if (state_r == S_SCHED && scan_done) addr_nxt = pick;
    unique case (state_r)
      S_WR: begin
        unique case (func_r)
          FN_ADMIT: begin
            mem_we       = 1'b1;
            wd.state     = ST_RUNNABLE;
            wd.queue     = qc_r;
            wd.arrival   = now_r;
            wd.run_stamp = now_r;
            wd.prio      = prio_r;
            wd.size      = size_r;
            wd.tenths    = '0;
          end
          FN_STATE: begin
            mem_we   = 1'b1;
            wd.state = ts_r;
          end
          FN_CHGQ: begin
            mem_we   = (eff_state != ST_UNUSED);
            wd.queue = qc_r;
          end
          FN_SCHED: begin
            mem_we       = 1'b1;
            wd.state     = ST_BLOCKED;
            wd.run_stamp = now_r;
            if (rd_data_r.tenths != 16'hFFFF) wd.tenths = rd_data_r.tenths + 16'd1;
          end
          default: ;
        endcase
      end
      S_AGE: begin
        mem_wa   = p1_idx_r;
        wd.queue = Q_RR;
        mem_we   = p1_v_r && (eff_state == ST_RUNNABLE) && (rd_data_r.queue != Q_RR)
                   && ((now_r - rd_data_r.run_stamp) > thr_r);
      end
      default: ;
    endcase
    mem_wd = wd;
  end

  // hold command and results
  logic       res_found_r;
  logic [5:0] res_chosen_r;
  logic [1:0] res_oldq_r, res_from_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_func;
      qc_r         <= (in_qc > Q_BJ) ? Q_BJ : in_qc;
      ts_r         <= (in_ts > ST_BLOCKED) ? ST_BLOCKED : in_ts;
      now_r        <= in_tdata[44:13];
      prio_r       <= in_tdata[52:45];
      size_r       <= in_tdata[68:53];
      res_found_r  <= 1'b0;
      res_chosen_r <= '0;
      res_oldq_r   <= Q_RR;
      res_from_r   <= FROM_NONE;
    end else if (state_r == S_WR && func_r == FN_CHGQ && eff_state != ST_UNUSED) begin
      res_found_r <= 1'b1;
      res_oldq_r  <= rd_data_r.queue;
    end else if (state_r == S_SCHED && scan_done && have) begin
      res_found_r  <= 1'b1;
      res_chosen_r <= 6'(pick);
      res_from_r   <= pick_from;
    end
    addr_r <= addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      lrr_r   <= IW'(ENTRIES - 1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_SCHED && scan_done && have && pick_from == FROM_RR) lrr_r <= pick;
    end
  end

  // output register
  logic [15:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_free)
      out_data_r <= {5'd0, res_from_r, res_oldq_r, res_chosen_r, res_found_r};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_IMP(a_pipe_in_scan, clk, rst_n, p1_v_r, (state_r == S_AGE || state_r == S_SCHED))
  `ASSERT_NXT(a_resp_loads, clk, rst_n, (state_r == S_RESP && out_free), out_tvalid_r)
  `ASSERT_IMP(a_age_to_rr, clk, rst_n, (state_r == S_AGE && mem_we), (mem_wd.queue == Q_RR))

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import mlqs_pkg::*;

  localparam int NSLOT = 64;
  localparam int WATCH_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // func, slot, queue_class, task_state, now, priority_req, task_size
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // found, chosen_slot, prev_queue, picked_from
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  // laid out like out_tdata: found in bit 0, picked_from on top
  typedef struct packed {
    logic [1:0] from;
    logic [1:0] oldq;
    logic [5:0] slot;
    logic       found;
  } verdict_t;

  multilevel_queue_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow task table and registers
  logic [31:0] thr;
  logic [15:0] w_prio, w_arr, w_exec, w_size;
  logic [1:0]  t_state [NSLOT];
  logic [1:0]  t_queue [NSLOT];
  logic [31:0] t_arr   [NSLOT];
  logic [31:0] t_last  [NSLOT];
  logic [7:0]  t_prio  [NSLOT];
  logic [15:0] t_size  [NSLOT];
  logic [15:0] t_tenth [NSLOT];
  bit          t_admitted [NSLOT];
  logic [5:0]  rr_last;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int idle_cycles = 0;
  logic [31:0] clock_now = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rank(int i);
    return 64'd10 * t_prio[i] * w_prio + 64'd10 * t_arr[i] * w_arr
         + 64'(t_tenth[i]) * w_exec + 64'd10 * t_size[i] * w_size;
  endfunction

  // advance the shadow table by one command and return its verdict
  function automatic verdict_t schedule_step(logic [2:0] fn, logic [5:0] s,
      logic [1:0] qc, logic [1:0] ts, logic [31:0] tnow, logic [7:0] pr,
      logic [15:0] sz);
    verdict_t v;
    bit have;
    int pick;
    int idx;
    logic [31:0] best_arr;
    logic [63:0] best_rank, r;
    v = '{found: 1'b0, slot: 6'd0, oldq: 2'd0, from: FROM_NONE};
    if (qc > Q_BJ) qc = Q_BJ;
    if (ts > ST_BLOCKED) ts = ST_BLOCKED;
    have = 0;
    pick = 0;
    case (fn)
      FN_ADMIT: begin
        t_state[s] = ST_RUNNABLE; t_queue[s] = qc; t_arr[s] = tnow;
        t_last[s] = tnow; t_prio[s] = pr; t_size[s] = sz; t_tenth[s] = 0;
        t_admitted[s] = 1;
      end
      FN_STATE: t_state[s] = ts;
      FN_CHGQ: begin
        if (t_state[s] != ST_UNUSED) begin
          v.found = 1; v.oldq = t_queue[s]; t_queue[s] = qc;
        end
      end
      FN_AGE: begin
        for (int i = 0; i < NSLOT; i++)
          if (t_state[i] == ST_RUNNABLE && t_queue[i] != Q_RR &&
              (tnow - t_last[i]) > thr)
            t_queue[i] = Q_RR;
      end
      FN_SCHED: begin
        for (int k = 1; k <= NSLOT && !have; k++) begin
          idx = (rr_last + k) % NSLOT;
          if (t_state[idx] == ST_RUNNABLE && t_queue[idx] == Q_RR) begin
            have = 1; pick = idx; v.from = FROM_RR;
          end
        end
        if (have) rr_last = 6'(pick);
        best_arr = 0;
        for (int i = 0; i < NSLOT && v.from != FROM_RR; i++)
          if (t_state[i] == ST_RUNNABLE && t_queue[i] == Q_LC &&
              (!have || t_arr[i] > best_arr)) begin
            have = 1; pick = i; best_arr = t_arr[i]; v.from = FROM_LC;
          end
        best_rank = 0;
        for (int i = 0; i < NSLOT && !have || (i < NSLOT && v.from == FROM_BJ);
             i++)
          if (t_state[i] == ST_RUNNABLE && t_queue[i] == Q_BJ) begin
            r = rank(i);
            if (v.from != FROM_BJ || r < best_rank) begin
              have = 1; pick = i; best_rank = r; v.from = FROM_BJ;
            end
          end
        if (have) begin
          v.found = 1; v.slot = 6'(pick);
          t_state[pick] = ST_BLOCKED; t_last[pick] = tnow;
          if (t_tenth[pick] != 16'hFFFF) t_tenth[pick]++;
        end else v.from = FROM_NONE;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // drive one command and queue its predicted verdict; valid stays up
  // until the next command or an idle cycle replaces it
  task automatic send_command(logic [2:0] fn, logic [5:0] s, logic [1:0] qc,
      logic [1:0] ts, logic [31:0] tnow, logic [7:0] pr, logic [15:0] sz);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'd0, sz, pr, tnow, ts, qc, s, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_verdicts.push_back(schedule_step(fn, s, qc, ts, tnow, pr, sz));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [31:0] d);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_AGING: thr = d;
      REG_PRIO:  w_prio = d[15:0];
      REG_ARR:   w_arr = d[15:0];
      REG_EXEC:  w_exec = d[15:0];
      default:   w_size = d[15:0];
    endcase
    @(negedge clk);
  endtask

  // random command; set state only on slots that have been admitted
  task automatic random_command;
    logic [2:0] fn;
    logic [5:0] s;
    int pick;
    pick = $urandom_range(99);
    s = 6'($urandom_range(NSLOT - 1));
    clock_now += $urandom_range(3000);
    if (pick < 25) fn = FN_ADMIT;
    else if (pick < 40) fn = FN_STATE;
    else if (pick < 52) fn = FN_CHGQ;
    else if (pick < 62) fn = FN_AGE;
    else if (pick < 95) fn = FN_SCHED;
    else fn = 3'($urandom_range(7, 5));
    if (fn == FN_STATE && !t_admitted[s]) fn = FN_ADMIT;
    send_command(fn, s, 2'($urandom_range(3)), 2'($urandom_range(3)),
                 ($urandom_range(9) == 0) ? $urandom : clock_now,
                 8'($urandom_range(255)), 16'($urandom_range(65535)));
  endtask

  task automatic test_directed;
    send_command(FN_SCHED, 0, 0, 0, 0, 0, 0);
    send_command(FN_CHGQ, 5, Q_LC, 0, 0, 0, 0);
    send_command(FN_ADMIT, 0, Q_RR, 0, 32'd10, 8'd0, 16'd0);
    send_command(FN_ADMIT, 63, Q_LC, 0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    send_command(FN_ADMIT, 7, Q_LC, 0, 32'hFFFF_FFFF, 8'd3, 16'd9);
    send_command(FN_ADMIT, 12, 2'd3, 0, 32'd100, 8'd1, 16'd1);
    send_command(FN_ADMIT, 13, Q_BJ, 0, 32'd50, 8'd1, 16'd1);
    send_command(FN_SCHED, 0, 0, 0, 32'd20, 0, 0);
    send_command(FN_SCHED, 0, 0, 0, 32'd30, 0, 0);
    send_command(FN_SCHED, 0, 0, 0, 32'd40, 0, 0);
    send_command(FN_SCHED, 0, 0, 0, 32'd40, 0, 0);
    send_command(FN_SCHED, 0, 0, 0, 32'd40, 0, 0);
    send_command(FN_SCHED, 0, 0, 0, 32'd40, 0, 0);
    send_command(FN_STATE, 63, 0, 2'd3, 0, 0, 0);
    send_command(FN_STATE, 7, 0, ST_RUNNABLE, 0, 0, 0);
    send_command(FN_CHGQ, 7, 2'd3, 0, 0, 0, 0);
    send_command(FN_STATE, 12, 0, ST_RUNNABLE, 0, 0, 0);
    send_command(FN_AGE, 0, 0, 0, 32'd100000, 0, 0);
    send_command(FN_SCHED, 0, 0, 0, 32'd100001, 0, 0);
    send_command(FN_STATE, 13, 0, ST_UNUSED, 0, 0, 0);
    send_command(3'd5, 1, 0, 0, 0, 0, 0);
    send_command(3'd7, 1, 3, 3, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_phase(int n, int sidle, int rstall);
    send_idle = sidle;
    recv_stall = rstall;
    repeat (n) random_command();
  endtask

  task automatic test_config_extremes;
    write_reg(REG_AGING, 32'd0);
    write_reg(REG_PRIO, 32'hFFFF);
    write_reg(REG_ARR, 32'd0);
    write_reg(REG_EXEC, 32'hFFFF);
    write_reg(REG_SIZE, 32'd0);
    test_random_phase(100, 0, 0);
    drain();
    write_reg(REG_AGING, 32'hFFFF_FFFF);
    write_reg(REG_PRIO, 32'd0);
    write_reg(REG_ARR, 32'hFFFF);
    write_reg(REG_EXEC, 32'd0);
    write_reg(REG_SIZE, 32'hFFFF);
    test_random_phase(100, 77, 0);
    drain();
    write_reg(REG_AGING, $urandom_range(20000));
    write_reg(REG_PRIO, $urandom_range(65535));
    write_reg(REG_ARR, $urandom_range(65535));
    write_reg(REG_EXEC, $urandom_range(65535));
    write_reg(REG_SIZE, $urandom_range(65535));
    test_random_phase(100, 0, 77);
    // pause until the block has caught up
    drain();
    test_random_phase(100, 26, 26);
    send_idle = 0;
    recv_stall = 0;
    test_random_phase(80, 0, 0);
    drain();
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !($urandom_range(99) < recv_stall);
  end

  // compare each result with the oldest verdict
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[10:0];
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.slot !== want.slot) report_mismatch("chosen_slot", got.slot, want.slot);
        if (got.oldq !== want.oldq) report_mismatch("prev_queue", got.oldq, want.oldq);
        if (got.from !== want.from) report_mismatch("picked_from", got.from, want.from);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    thr = 32'd8000; w_prio = 256; w_arr = 256; w_exec = 256; w_size = 256;
    rr_last = NSLOT - 1;
    for (int i = 0; i < NSLOT; i++) begin
      t_state[i] = ST_UNUSED; t_queue[i] = 0; t_arr[i] = 0; t_last[i] = 0;
      t_prio[i] = 0; t_size[i] = 0; t_tenth[i] = 0; t_admitted[i] = 0;
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
